>>> design/cps_pkg.sv
// Shared types and codes of the contactor precharge sequencer.
package cps_pkg;

   localparam int unsigned TimeWidth    = 32;
   localparam int unsigned PrechgWidth  = 16;
   localparam int unsigned CsrDataWidth = 16;
   localparam int unsigned CsrIdxWidth  = 3;

   typedef enum logic [1:0] {
      CMD_IGNITION = 2'd0,
      CMD_READY    = 2'd1,
      CMD_TICK     = 2'd2,
      CMD_ESTOP    = 2'd3
   } cmd_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_PRECHARGE_TIME = 3'd0,
      CSR_KEY_START      = 3'd1,
      CSR_ON_IS_HIGH     = 3'd2,
      CSR_MAIN_CHECK     = 3'd3,
      CSR_AUX_CHECK      = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [1:0]           command;
      logic [TimeWidth-1:0] now_ms;
      logic [1:0]           ignition_position;
      logic                 vehicle_ready;
      logic                 main_sense;
      logic                 aux_sense;
   } req_item_type;

   typedef struct packed {
      logic main_pin_level;
      logic aux_pin_level;
      logic main_connected;
      logic aux_connected;
      logic main_fault;
      logic aux_fault;
      logic precharge_active;
   } rsp_item_type;

endpackage

>>> design/cps_ifs.sv
// Valid/ready channel interfaces for sequencer requests and responses.
interface cps_req_if;
   logic                  valid;
   logic                  ready;
   cps_pkg::req_item_type item;

   modport source (output valid, output item, input ready);
   modport sink   (input valid, input item, output ready);
endinterface

interface cps_rsp_if;
   logic                  valid;
   logic                  ready;
   cps_pkg::rsp_item_type item;

   modport source (output valid, output item, input ready);
   modport sink   (input valid, input item, output ready);
endinterface

>>> design/contactor_precharge_sequencer_top.sv
// Contactor precharge sequencer: state update, result buffer and register port.
//
// Usage:
//  req_ch carries one item per event: ignition change, readiness change,
//  loop tick or emergency off, with a ms time stamp and the sensed levels.
//  rsp_ch returns exactly one item per request, holding the pin levels,
//  commanded contactor states, fault flags and precharge flag after it.
//  csr_* writes a register (no read-back); write only when idle.
// Responses are registered into the head entry, or the skid entry when stalled.
// Throughput: one item per cycle unless stalled; state update is one
//  compare/subtract pass between state registers and a two-entry result buffer.
// Stall: while the receiver holds off, one more request is taken into the
//  second buffer entry; then req_ch.ready drops until a response is taken.
// Reset (synchronous, active high): contactors open, flags clear, buffer
//  empty, registers at defaults (1000 ms, key start 2, active-high pins,
//  sense checks off).
module contactor_precharge_sequencer_top (
   input  logic                                 clock,
   input  logic                                 reset,
   cps_req_if.sink                              req_ch,
   cps_rsp_if.source                            rsp_ch,
   input  logic                                 csr_write_enable,
   input  logic [cps_pkg::CsrIdxWidth-1:0]      csr_index,
   input  logic [cps_pkg::CsrDataWidth-1:0]     csr_write_data
);

   // configuration
   logic [cps_pkg::PrechgWidth-1:0] prechg_time_ff;
   logic [1:0]                      key_start_ff;
   logic                            on_high_ff;
   logic                            main_chk_ff;
   logic                            aux_chk_ff;

   // sequencing state
   logic                          main_drv_ff, main_drv_in;
   logic                          aux_drv_ff, aux_drv_in;
   logic                          main_conn_ff, main_conn_in;
   logic                          aux_conn_ff, aux_conn_in;
   logic                          main_flt_ff, main_flt_in;
   logic                          aux_flt_ff, aux_flt_in;
   logic                          prechg_ff, prechg_in;
   logic [cps_pkg::TimeWidth-1:0] prechg_start_ff, prechg_start_in;

   // result buffer
   logic                  out_valid_ff, out_valid_in;
   logic                  skid_valid_ff, skid_valid_in;
   cps_pkg::rsp_item_type out_item_ff, out_item_in;
   cps_pkg::rsp_item_type skid_item_ff, skid_item_in;
   cps_pkg::rsp_item_type new_item;

   logic                          accept;
   logic                          pop;
   logic [cps_pkg::TimeWidth-1:0] elapsed;

   assign req_ch.ready = !skid_valid_ff;
   assign accept       = req_ch.valid && req_ch.ready;
   assign pop          = out_valid_ff && rsp_ch.ready;
   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.item  = out_item_ff;
   assign elapsed      = req_ch.item.now_ms - prechg_start_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prechg_time_ff <= cps_pkg::PrechgWidth'(1000);
         key_start_ff   <= 2'd2;
         on_high_ff     <= 1'b1;
         main_chk_ff    <= 1'b0;
         aux_chk_ff     <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            cps_pkg::CSR_PRECHARGE_TIME: prechg_time_ff <= csr_write_data;
            cps_pkg::CSR_KEY_START:      key_start_ff   <= csr_write_data[1:0];
            cps_pkg::CSR_ON_IS_HIGH:     on_high_ff     <= csr_write_data[0];
            cps_pkg::CSR_MAIN_CHECK:     main_chk_ff    <= csr_write_data[0];
            cps_pkg::CSR_AUX_CHECK:      aux_chk_ff     <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      main_drv_in     = main_drv_ff;
      aux_drv_in      = aux_drv_ff;
      main_conn_in    = main_conn_ff;
      aux_conn_in     = aux_conn_ff;
      main_flt_in     = main_flt_ff;
      aux_flt_in      = aux_flt_ff;
      prechg_in       = prechg_ff;
      prechg_start_in = prechg_start_ff;
      case (cps_pkg::cmd_type'(req_ch.item.command))
         cps_pkg::CMD_IGNITION: begin
            if (req_ch.item.ignition_position == key_start_ff &&
                req_ch.item.vehicle_ready && !main_conn_ff) begin
               aux_drv_in      = 1'b1;
               aux_conn_in     = 1'b1;
               prechg_in       = 1'b1;
               prechg_start_in = req_ch.item.now_ms;
            end else if (req_ch.item.ignition_position < key_start_ff) begin
               main_drv_in  = 1'b0;
               aux_drv_in   = 1'b0;
               main_conn_in = 1'b0;
               aux_conn_in  = 1'b0;
            end
         end
         cps_pkg::CMD_READY: begin
            if (!req_ch.item.vehicle_ready) begin
               main_drv_in  = 1'b0;
               aux_drv_in   = 1'b0;
               main_conn_in = 1'b0;
               aux_conn_in  = 1'b0;
            end
         end
         cps_pkg::CMD_TICK: begin
            if (prechg_ff &&
                elapsed > {{(cps_pkg::TimeWidth-cps_pkg::PrechgWidth){1'b0}},
                           prechg_time_ff}) begin
               prechg_in    = 1'b0;
               main_drv_in  = 1'b1;
               main_conn_in = 1'b1;
               aux_drv_in   = 1'b0;
               aux_conn_in  = 1'b0;
            end
            if (main_chk_ff) begin
               if ((req_ch.item.main_sense == on_high_ff) != main_conn_in) begin
                  main_drv_in = 1'b0;
                  main_flt_in = 1'b1;
               end else begin
                  main_flt_in = 1'b0;
               end
            end
            if (aux_chk_ff) begin
               if ((req_ch.item.aux_sense == on_high_ff) != aux_conn_in) begin
                  aux_drv_in = 1'b0;
                  aux_flt_in = 1'b1;
               end else begin
                  aux_flt_in = 1'b0;
               end
            end
         end
         cps_pkg::CMD_ESTOP: begin
            main_drv_in  = 1'b0;
            aux_drv_in   = 1'b0;
            main_conn_in = 1'b0;
            aux_conn_in  = 1'b0;
         end
         default: begin
            main_drv_in  = 1'b0;
            aux_drv_in   = 1'b0;
            main_conn_in = 1'b0;
            aux_conn_in  = 1'b0;
         end
      endcase

      new_item.main_pin_level   = main_drv_in ? on_high_ff : !on_high_ff;
      new_item.aux_pin_level    = aux_drv_in ? on_high_ff : !on_high_ff;
      new_item.main_connected   = main_conn_in;
      new_item.aux_connected    = aux_conn_in;
      new_item.main_fault       = main_flt_in;
      new_item.aux_fault        = aux_flt_in;
      new_item.precharge_active = prechg_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_drv_ff     <= 1'b0;
         aux_drv_ff      <= 1'b0;
         main_conn_ff    <= 1'b0;
         aux_conn_ff     <= 1'b0;
         main_flt_ff     <= 1'b0;
         aux_flt_ff      <= 1'b0;
         prechg_ff       <= 1'b0;
         prechg_start_ff <= '0;
      end else if (accept) begin
         main_drv_ff     <= main_drv_in;
         aux_drv_ff      <= aux_drv_in;
         main_conn_ff    <= main_conn_in;
         aux_conn_ff     <= aux_conn_in;
         main_flt_ff     <= main_flt_in;
         aux_flt_ff      <= aux_flt_in;
         prechg_ff       <= prechg_in;
         prechg_start_ff <= prechg_start_in;
      end
   end

   // two-entry result buffer: skid entry fills only while the head is stalled
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_item_in   = out_item_ff;
      skid_item_in  = skid_item_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_item_in   = skid_item_ff;
            skid_valid_in = 1'b0;
         end
      end else begin
         out_valid_in = out_valid_ff && !pop;
         if (accept) begin
            if (out_valid_in) begin
               skid_item_in  = new_item;
               skid_valid_in = 1'b1;
            end else begin
               out_item_in  = new_item;
               out_valid_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_item_ff  <= out_item_in;
      skid_item_ff <= skid_item_in;
   end

endmodule

>>> design/cps_checker.sv
// Port-level assertions for the contactor precharge sequencer, with bind.
module cps_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input cps_pkg::rsp_item_type rsp_item
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
      else $error("stalled response item changed or vanished");

   a_item_out: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted item produced no response");

   a_not_both: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_item.main_connected && rsp_item.aux_connected))
      else $error("main and precharge both commanded closed");

   a_prechg_main: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.precharge_active |-> !rsp_item.main_connected)
      else $error("precharge timing active with main closed");

endmodule

bind contactor_precharge_sequencer_top cps_checker u_cps_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_item  (rsp_ch.item)
);
